>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/imts_pkg.sv
// package with types and constants of the i2c message transfer sequencer
`timescale 1ns / 1ps

package imts_pkg;

  localparam logic [2:0] OP_LOAD_DESC = 3'd0;
  localparam logic [2:0] OP_LOAD_BYTE = 3'd1;
  localparam logic [2:0] OP_START     = 3'd2;
  localparam logic [2:0] OP_IRQ       = 3'd3;
  localparam logic [2:0] OP_READ_BYTE = 3'd4;

  localparam logic [1:0] SEL_DATA = 2'd0;
  localparam logic [1:0] SEL_STAT = 2'd1;
  localparam logic [1:0] SEL_CTRL = 2'd2;
  localparam logic [1:0] SEL_NONE = 2'd3;

  localparam logic [1:0] XS_RUN  = 2'd0;
  localparam logic [1:0] XS_OK   = 2'd1;
  localparam logic [1:0] XS_NACK = 2'd2;

  localparam logic [7:0] CMD_START_RX  = 8'hb0;
  localparam logic [7:0] CMD_START_TX  = 8'hf0;
  localparam logic [7:0] CMD_STOP_RX   = 8'h90;
  localparam logic [7:0] CMD_STOP_TX   = 8'hd0;
  localparam logic [7:0] CTL_ACK       = 8'haf;
  localparam logic [7:0] CTL_NO_ACK    = 8'h2f;
  localparam logic [7:0] STAT_NACK     = 8'h01;
  localparam logic [7:0] CTL_PEND_MASK = 8'hef;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_READ,
    PH_WRITE,
    PH_STOP
  } phase_t;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_FETCH,
    ST_EXEC,
    ST_NORM,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic fetch;
    logic exec;
    logic reduce;
    logic settle;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic has_res;
    logic at_last;
    logic norm_busy;
  } sts_t;

endpackage

>>> rtl/i2c_message_transfer_sequencer_top.sv
// top level of the i2c message transfer sequencer
//
// input channel: in_valid / in_stall with op and its operand fields. ops load the
// message descriptor table and the shared byte buffer, start a transfer, report a
// controller interrupt or read back a buffer byte.
// output channel: out_valid / out_stall carrying controller register writes
// (reg_select, reg_value), read_data, xfer_status and last on the final result.
// one request is handled at a time: fetch from the tables, execute, then show
// zero to three results. moving on to the next message can add buffer offset
// wrap steps, one subtract per cycle, before the results are shown.
// while a request or its results are pending, in_stall stays high, and while
// out_stall is high the shown result holds.
// synchronous reset returns to idle with message count one; table and buffer
// contents are kept and are undefined until loaded.
`timescale 1ns / 1ps

module i2c_message_transfer_sequencer_top import imts_pkg::*; #(
  parameter int unsigned MAX_MSGS  = 8,
  parameter int unsigned BUF_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] op,
  input  logic [7:0] index,
  input  logic [6:0] dev_addr,
  input  logic       is_read,
  input  logic [7:0] msg_len,
  input  logic [7:0] data_byte,
  input  logic [3:0] msg_total,
  input  logic [7:0] bus_status,
  input  logic [7:0] rx_byte,
  input  logic [7:0] control_now,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] reg_select,
  output logic [7:0] reg_value,
  output logic [7:0] read_data,
  output logic [1:0] xfer_status,
  output logic       last
);

  cmd_t cmd;
  sts_t sts;

  imts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  imts_datapath #(
    .MAX_MSGS  (MAX_MSGS),
    .BUF_DEPTH (BUF_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (op),
    .index       (index),
    .dev_addr    (dev_addr),
    .is_read     (is_read),
    .msg_len     (msg_len),
    .data_byte   (data_byte),
    .msg_total   (msg_total),
    .bus_status  (bus_status),
    .rx_byte     (rx_byte),
    .control_now (control_now),
    .reg_select  (reg_select),
    .reg_value   (reg_value),
    .read_data   (read_data),
    .xfer_status (xfer_status),
    .last        (last)
  );

endmodule

>>> rtl/imts_ctrl.sv
// controller state machine that steps each request through fetch, execute, normalize and output
`timescale 1ns / 1ps

module imts_ctrl import imts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_WAIT: begin
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        if (sts.norm_busy) begin
          cmd.reduce = 1'b1;
        end else begin
          cmd.settle = 1'b1;
          state_next = sts.has_res ? ST_OUT : ST_WAIT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.pop = 1'b1;
          if (sts.at_last) begin
            state_next = ST_WAIT;
          end
        end
      end
      default: begin
        state_next = ST_WAIT;
      end
    endcase
  end

endmodule

>>> rtl/imts_datapath.sv
// datapath with descriptor table, byte buffer, transfer state and result registers
`timescale 1ns / 1ps

module imts_datapath import imts_pkg::*; #(
  parameter int unsigned MAX_MSGS  = 8,
  parameter int unsigned BUF_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [2:0] op,
  input  logic [7:0] index,
  input  logic [6:0] dev_addr,
  input  logic       is_read,
  input  logic [7:0] msg_len,
  input  logic [7:0] data_byte,
  input  logic [3:0] msg_total,
  input  logic [7:0] bus_status,
  input  logic [7:0] rx_byte,
  input  logic [7:0] control_now,
  output logic [1:0] reg_select,
  output logic [7:0] reg_value,
  output logic [7:0] read_data,
  output logic [1:0] xfer_status,
  output logic       last
);

  localparam int unsigned MIW = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
  localparam int unsigned MCW = $clog2(MAX_MSGS + 1);
  localparam int unsigned TW  = (MCW > 4) ? MCW : 4;
  localparam int unsigned AW  = $clog2(BUF_DEPTH);
  localparam int unsigned IW  = (AW > 8) ? AW : 8;
  localparam int unsigned BW  = IW + 1;

  // captured request
  logic [2:0] req_op;
  logic [7:0] req_index;
  logic [6:0] req_dev_addr;
  logic       req_is_read;
  logic [7:0] req_msg_len;
  logic [7:0] req_data_byte;
  logic [3:0] req_msg_total;
  logic [7:0] req_bus_status;
  logic [7:0] req_rx_byte;
  logic [7:0] req_control_now;

  // transfer state
  phase_t           phase;
  phase_t           phase_next;
  logic [MIW-1:0]   msg_index;
  logic [MIW-1:0]   msg_index_next;
  logic [MCW-1:0]   msg_count;
  logic [MCW-1:0]   msg_count_next;
  logic [7:0]       byte_pos;
  logic [7:0]       byte_pos_next;
  logic [BW-1:0]    ptr;
  logic [BW-1:0]    ptr_next;
  logic [AW-1:0]    base;
  logic             rebase;
  logic             rebase_next;

  // memories and their read registers
  logic [15:0]      desc_mem [MAX_MSGS];
  logic [7:0]       buf_mem  [BUF_DEPTH];
  logic [15:0]      desc_a;
  logic [15:0]      desc_b;
  logic [7:0]       buf_rd;

  // results
  logic [1:0]       res_sel [3];
  logic [7:0]       res_val [3];
  logic [1:0]       res_cnt;
  logic [1:0]       res_status;
  logic [7:0]       res_rd;
  logic [1:0]       optr;

  // execute logic
  logic [1:0]       sel_n [3];
  logic [7:0]       val_n [3];
  logic [1:0]       n;
  logic [1:0]       st_n;
  logic [7:0]       rd_n;
  logic             desc_we;
  logic             buf_we;
  logic [AW-1:0]    buf_waddr;
  logic [7:0]       buf_wdata;
  logic [MIW-1:0]   desc_addr_a;
  logic [MIW-1:0]   desc_addr_b;
  logic [AW-1:0]    buf_raddr;
  logic [BW-1:0]    idx_ext;
  logic             idx_ok;
  logic [MCW-1:0]   idx_p1;
  logic [BW-1:0]    ptr_inc;
  logic [TW-1:0]    tot;
  logic             do_start;
  logic [15:0]      start_desc;
  logic             do_stop;
  logic [1:0]       stop_code;
  logic             do_byte;
  logic             do_ack;
  logic [7:0]       ack_val;
  logic             chk_write;
  logic             chk_read;
  logic             done_msg;
  logic [7:0]       rp;
  logic [7:0]       cur_len;
  logic             cur_rd;
  logic             nack;

  assign idx_ext     = BW'(req_index);
  assign idx_ok      = idx_ext < BW'(BUF_DEPTH);
  assign idx_p1      = MCW'(msg_index) + MCW'(1);
  assign desc_addr_a = (req_op == OP_START) ? '0 : msg_index;
  assign desc_addr_b = (idx_p1 < MCW'(MAX_MSGS)) ? idx_p1[MIW-1:0] : '0;
  assign buf_raddr   = (req_op == OP_READ_BYTE) ? idx_ext[AW-1:0] : ptr[AW-1:0];
  assign ptr_inc     = (ptr[AW-1:0] == AW'(BUF_DEPTH - 1)) ? '0 : ptr + BW'(1);
  assign cur_len     = desc_a[15:8];
  assign cur_rd      = desc_a[7];
  assign nack        = (req_bus_status & STAT_NACK) != 8'd0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op          <= op;
      req_index       <= index;
      req_dev_addr    <= dev_addr;
      req_is_read     <= is_read;
      req_msg_len     <= msg_len;
      req_data_byte   <= data_byte;
      req_msg_total   <= msg_total;
      req_bus_status  <= bus_status;
      req_rx_byte     <= rx_byte;
      req_control_now <= control_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      desc_a <= desc_mem[desc_addr_a];
      desc_b <= desc_mem[desc_addr_b];
      buf_rd <= buf_mem[buf_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && desc_we) begin
      desc_mem[req_index[MIW-1:0]] <= {req_msg_len, req_is_read, req_dev_addr};
    end
    if (cmd.exec && buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
  end

  always_comb begin
    phase_next     = phase;
    msg_index_next = msg_index;
    msg_count_next = msg_count;
    byte_pos_next  = byte_pos;
    ptr_next       = ptr;
    rebase_next    = rebase;
    desc_we        = 1'b0;
    buf_we         = 1'b0;
    buf_waddr      = idx_ext[AW-1:0];
    buf_wdata      = req_data_byte;
    st_n           = XS_RUN;
    rd_n           = 8'd0;
    do_start       = 1'b0;
    start_desc     = desc_a;
    do_stop        = 1'b0;
    stop_code      = XS_OK;
    do_byte        = 1'b0;
    do_ack         = 1'b0;
    ack_val        = CTL_ACK;
    chk_write      = 1'b0;
    chk_read       = 1'b0;
    done_msg       = 1'b0;
    rp             = byte_pos;
    tot            = TW'(req_msg_total);
    n              = 2'd0;
    for (int i = 0; i < 3; i++) begin
      sel_n[i] = SEL_NONE;
      val_n[i] = 8'd0;
    end

    case (req_op)
      OP_LOAD_DESC: begin
        desc_we = req_index < 8'(MAX_MSGS);
      end
      OP_LOAD_BYTE: begin
        buf_we = idx_ok;
      end
      OP_START: begin
        if (tot == '0) begin
          tot = TW'(1);
        end else if (tot > TW'(MAX_MSGS)) begin
          tot = TW'(MAX_MSGS);
        end
        msg_count_next = tot[MCW-1:0];
        msg_index_next = '0;
        byte_pos_next  = 8'd0;
        ptr_next       = '0;
        rebase_next    = 1'b1;
        phase_next     = PH_START;
        do_start       = 1'b1;
      end
      OP_IRQ: begin
        case (phase)
          PH_START: begin
            if (nack) begin
              do_stop   = 1'b1;
              stop_code = XS_NACK;
            end else if (cur_rd) begin
              phase_next = PH_READ;
              chk_read   = 1'b1;
            end else begin
              phase_next = PH_WRITE;
              chk_write  = 1'b1;
            end
          end
          PH_WRITE: begin
            chk_write = 1'b1;
          end
          PH_READ: begin
            if (byte_pos != 8'hff) begin
              buf_we        = 1'b1;
              buf_waddr     = ptr[AW-1:0];
              buf_wdata     = req_rx_byte;
              rp            = byte_pos + 8'd1;
              byte_pos_next = rp;
              ptr_next      = ptr_inc;
            end
            chk_read = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (chk_write) begin
      if (nack) begin
        do_stop   = 1'b1;
        stop_code = XS_NACK;
      end else if (byte_pos < cur_len) begin
        do_byte       = 1'b1;
        byte_pos_next = byte_pos + 8'd1;
        ptr_next      = ptr_inc;
      end else begin
        done_msg = 1'b1;
      end
    end

    if (chk_read) begin
      if (rp < cur_len) begin
        do_ack  = 1'b1;
        ack_val = (({1'b0, rp} + 9'd1) >= {1'b0, cur_len}) ? CTL_NO_ACK : CTL_ACK;
      end else begin
        done_msg = 1'b1;
      end
    end

    if (done_msg) begin
      if (idx_p1 < msg_count) begin
        ptr_next       = BW'(base) + BW'(cur_len);
        rebase_next    = 1'b1;
        msg_index_next = idx_p1[MIW-1:0];
        byte_pos_next  = 8'd0;
        phase_next     = PH_START;
        do_start       = 1'b1;
        start_desc     = desc_b;
      end else begin
        do_stop   = 1'b1;
        stop_code = XS_OK;
      end
    end

    if (do_stop) begin
      phase_next = PH_STOP;
      st_n       = stop_code;
    end

    if (do_start) begin
      sel_n[n] = SEL_DATA;
      val_n[n] = {start_desc[6:0], start_desc[7]};
      n = n + 2'd1;
      sel_n[n] = SEL_STAT;
      val_n[n] = start_desc[7] ? CMD_START_RX : CMD_START_TX;
      n = n + 2'd1;
    end
    if (do_stop) begin
      sel_n[n] = SEL_STAT;
      val_n[n] = cur_rd ? CMD_STOP_RX : CMD_STOP_TX;
      n = n + 2'd1;
      sel_n[n] = SEL_CTRL;
      val_n[n] = CTL_ACK;
      n = n + 2'd1;
    end
    if (do_byte) begin
      sel_n[n] = SEL_DATA;
      val_n[n] = buf_rd;
      n = n + 2'd1;
    end
    if (do_ack) begin
      sel_n[n] = SEL_CTRL;
      val_n[n] = ack_val;
      n = n + 2'd1;
    end
    if (req_op == OP_IRQ) begin
      sel_n[n] = SEL_CTRL;
      val_n[n] = req_control_now & CTL_PEND_MASK;
      n = n + 2'd1;
    end
    if (req_op == OP_READ_BYTE) begin
      sel_n[n] = SEL_NONE;
      val_n[n] = 8'd0;
      rd_n = idx_ok ? buf_rd : 8'd0;
      n = n + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_sel    <= sel_n;
      res_val    <= val_n;
      res_status <= st_n;
      res_rd     <= rd_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      msg_index <= '0;
      msg_count <= MCW'(1);
      byte_pos  <= 8'd0;
      ptr       <= '0;
      base      <= '0;
      rebase    <= 1'b0;
      res_cnt   <= 2'd0;
      optr      <= 2'd0;
    end else begin
      if (cmd.exec) begin
        phase     <= phase_next;
        msg_index <= msg_index_next;
        msg_count <= msg_count_next;
        byte_pos  <= byte_pos_next;
        ptr       <= ptr_next;
        rebase    <= rebase_next;
        res_cnt   <= n;
        optr      <= 2'd0;
      end
      if (cmd.reduce) begin
        ptr <= ptr - BW'(BUF_DEPTH);
      end
      if (cmd.settle && rebase) begin
        base   <= ptr[AW-1:0];
        rebase <= 1'b0;
      end
      if (cmd.pop) begin
        optr <= optr + 2'd1;
      end
    end
  end

  assign reg_select    = res_sel[optr];
  assign reg_value     = res_val[optr];
  assign read_data     = res_rd;
  assign xfer_status   = res_status;
  assign last          = (optr == (res_cnt - 2'd1));
  assign sts.has_res   = res_cnt != 2'd0;
  assign sts.at_last   = last;
  assign sts.norm_busy = ptr >= BW'(BUF_DEPTH);

endmodule

>>> rtl/imts_checker.sv
// port-level checker for the i2c message transfer sequencer and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imts_checker import imts_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] reg_select,
  input logic [7:0] reg_value,
  input logic [7:0] read_data,
  input logic [1:0] xfer_status,
  input logic       last
);

  `CHK_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(reg_select) && $stable(reg_value) && $stable(last), "stalled result changed")
  `CHK_IMPLY(a_busy, out_valid, in_stall, "request accepted while results pending")
  `CHK_NEXT(a_done, out_valid && !out_stall && last, !out_valid, "result shown after last")
  `CHK_IMPLY(a_rdata, out_valid && (read_data != 8'd0), reg_select == SEL_NONE, "read data on a register write")
  `CHK_IMPLY(a_none, out_valid && (reg_select == SEL_NONE), last && (xfer_status == XS_RUN), "read result not alone")

endmodule

bind i2c_message_transfer_sequencer_top imts_checker u_imts_checker (.*);
